[rtl/core/gcr_pkg.sv]
// Shared types and constants for the glyph column rasterizer.
`default_nettype none

package gcr_pkg;

   localparam int SCREEN_WIDTH_DEFAULT  = 480;
   localparam int SCREEN_HEIGHT_DEFAULT = 320;

   // Work queue between the byte classifier and the pixel serializer.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int BITS_PER_BYTE = 8;
   localparam int COORD_W       = 10;
   localparam int WIDE_COORD_W  = COORD_W + 1;
   localparam int CURSOR_W      = 9;
   localparam int COLOR_W       = 16;
   localparam int OFFSET_W      = 4;

   localparam logic [4:0] FONT_ROWS_SHORT = 5'd12;
   localparam logic [4:0] FONT_ROWS_TALL  = 5'd16;

   // One font byte after classification. Bit i of pixel_mask is the i-th
   // bit consumed (most significant font bit first) that yields a write.
   typedef struct packed {
      logic [BITS_PER_BYTE-1:0] pixel_mask;
      logic [CURSOR_W-1:0]      pixel_x;
      logic [COORD_W-1:0]       start_y;
      logic [COLOR_W-1:0]       color;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_push_type;

   typedef struct packed {
      logic            valid;
      logic            full;
      queue_entry_type entry;
   } queue_status_type;

endpackage

`default_nettype wire

[rtl/core/glyph_column_rasterizer.sv]
// Top level of the glyph column rasterizer.
`default_nettype none

// Expands font-table bytes into pixel writes. A byte with first_byte set
// latches the glyph origin and font height and restarts at the glyph's top
// left; bytes of a glyph whose origin is off screen are consumed without
// writes. The front classifier accepts one byte per cycle while its
// four-entry work queue has room and reduces each byte to a mask of the
// pixels it draws; bytes that draw nothing never reach the queue. The
// serializer behind it delivers one pixel write per cycle while the output
// is not stalled, one write for each set, on-screen bit of a byte (zero to
// eight), and that count sets the sustained input rate. The first write of
// a byte passes through the work queue, the current-byte register and the
// output register; the final write of each byte carries last.
module glyph_column_rasterizer #(
   parameter int SCREEN_WIDTH  = gcr_pkg::SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = gcr_pkg::SCREEN_HEIGHT_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire logic                              req_first_byte,
   input  wire logic [gcr_pkg::COORD_W-1:0]       req_origin_x,
   input  wire logic [gcr_pkg::COORD_W-1:0]       req_origin_y,
   input  wire logic                              req_font_tall,
   input  wire logic [gcr_pkg::BITS_PER_BYTE-1:0] req_glyph_byte,
   input  wire logic [gcr_pkg::COLOR_W-1:0]       req_pixel_color,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      logic [gcr_pkg::CURSOR_W-1:0]      rsp_cursor_row,
   output      logic [gcr_pkg::CURSOR_W-1:0]      rsp_cursor_col,
   output      logic [gcr_pkg::COLOR_W-1:0]       rsp_color_out,
   output      logic                              rsp_last
);
   import gcr_pkg::*;

   queue_push_type   push;
   queue_status_type queue;
   logic             pop;

   gcr_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_first_byte  (req_first_byte),
      .req_origin_x    (req_origin_x),
      .req_origin_y    (req_origin_y),
      .req_font_tall   (req_font_tall),
      .req_glyph_byte  (req_glyph_byte),
      .req_pixel_color (req_pixel_color),
      .queue_full      (queue.full),
      .push            (push)
   );

   gcr_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .status (queue)
   );

   gcr_back #(
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .queue          (queue),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_color_out  (rsp_color_out),
      .rsp_last       (rsp_last)
   );

   // The classifier must never push into a full queue.
   assert property (@(posedge clock) disable iff (reset) push.valid |-> !queue.full)
      else $error("push into full work queue");

   // The serializer must only pop when the queue holds an entry.
   assert property (@(posedge clock) disable iff (reset) pop |-> queue.valid)
      else $error("pop from empty work queue");

   // A transaction that is not the last of its byte is followed at once by another.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> rsp_valid)
      else $error("pixel writes of one byte interrupted");

   // Nothing can be delivered in the cycle right after a reset cycle.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("pixel write right after reset");

endmodule

`default_nettype wire

[rtl/core/gcr_front.sv]
// Byte classifier: tracks glyph position and turns each font byte into a pixel mask.
`default_nettype none

module gcr_front #(
   parameter int SCREEN_WIDTH  = gcr_pkg::SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = gcr_pkg::SCREEN_HEIGHT_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic                           req_first_byte,
   input  wire logic [gcr_pkg::COORD_W-1:0]    req_origin_x,
   input  wire logic [gcr_pkg::COORD_W-1:0]    req_origin_y,
   input  wire logic                           req_font_tall,
   input  wire logic [gcr_pkg::BITS_PER_BYTE-1:0] req_glyph_byte,
   input  wire logic [gcr_pkg::COLOR_W-1:0]    req_pixel_color,
   input  wire logic                           queue_full,
   output      gcr_pkg::queue_push_type        push
);
   import gcr_pkg::*;

   localparam logic [WIDE_COORD_W-1:0] WidthLimit  = WIDE_COORD_W'(SCREEN_WIDTH);
   localparam logic [WIDE_COORD_W-1:0] HeightLimit = WIDE_COORD_W'(SCREEN_HEIGHT);

   logic [COORD_W-1:0]  base_x_ff, base_x_in;
   logic [COORD_W-1:0]  base_y_ff, base_y_in;
   logic [OFFSET_W-1:0] column_ff, column_in;
   logic [OFFSET_W-1:0] row_ff, row_in;
   logic                tall_ff, tall_in;
   logic                skipped_ff, skipped_in;

   logic                    accept;
   logic [OFFSET_W-1:0]     column_cur, row_cur;
   logic [4:0]              height, remaining, row_sum;
   logic [3:0]              bit_count;
   logic [WIDE_COORD_W-1:0] pixel_x, start_y;
   logic [WIDE_COORD_W-1:0] row_y;
   logic [BITS_PER_BYTE-1:0] mask;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      base_x_in  = base_x_ff;
      base_y_in  = base_y_ff;
      tall_in    = tall_ff;
      skipped_in = skipped_ff;
      column_cur = column_ff;
      row_cur    = row_ff;
      if (req_first_byte) begin
         base_x_in  = req_origin_x;
         base_y_in  = req_origin_y;
         tall_in    = req_font_tall;
         column_cur = '0;
         row_cur    = '0;
         skipped_in = ({1'b0, req_origin_x} >= WidthLimit) ||
                      ({1'b0, req_origin_y} >= HeightLimit);
      end

      height    = tall_in ? FONT_ROWS_TALL : FONT_ROWS_SHORT;
      remaining = height - {1'b0, row_cur};
      bit_count = (remaining >= 5'd8) ? 4'd8 : remaining[3:0];
      row_sum   = {1'b0, row_cur} + {1'b0, bit_count};

      // A byte that reaches the font height closes the column.
      column_in = column_cur;
      row_in    = row_cur;
      if (!skipped_in) begin
         if (row_sum >= height) begin
            row_in    = '0;
            column_in = column_cur + 1'b1;
         end else begin
            row_in = row_sum[OFFSET_W-1:0];
         end
      end

      pixel_x = {1'b0, base_x_in} + WIDE_COORD_W'(column_cur);
      start_y = {1'b0, base_y_in} + WIDE_COORD_W'(row_cur);
      for (int i = 0; i < BITS_PER_BYTE; i++) begin
         row_y   = start_y + WIDE_COORD_W'(i);
         mask[i] = req_glyph_byte[BITS_PER_BYTE-1-i] && (4'(i) < bit_count) &&
                   (pixel_x < WidthLimit) && (row_y < HeightLimit);
      end

      push.valid             = accept && !skipped_in && (mask != '0);
      push.entry.pixel_mask  = mask;
      push.entry.pixel_x     = pixel_x[CURSOR_W-1:0];
      push.entry.start_y     = start_y[COORD_W-1:0];
      push.entry.color       = req_pixel_color;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_x_ff  <= '0;
         base_y_ff  <= '0;
         column_ff  <= '0;
         row_ff     <= '0;
         tall_ff    <= 1'b0;
         skipped_ff <= 1'b1;
      end else if (accept) begin
         base_x_ff  <= base_x_in;
         base_y_ff  <= base_y_in;
         column_ff  <= column_in;
         row_ff     <= row_in;
         tall_ff    <= tall_in;
         skipped_ff <= skipped_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/gcr_queue.sv]
// Small work queue between the byte classifier and the pixel serializer.
`default_nettype none

module gcr_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire gcr_pkg::queue_push_type   push,
   input  wire logic                      pop,
   output      gcr_pkg::queue_status_type status
);
   import gcr_pkg::*;

   queue_entry_type        entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic                   do_pop;

   assign do_pop       = pop && (count_ff != '0);
   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.entry = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push.valid && !status.full) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid && !status.full) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push.valid && !status.full, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

[rtl/core/gcr_back.sv]
// Pixel serializer: emits one pixel write per cycle, while the output is not stalled, from the queued masks.
`default_nettype none

module gcr_back #(
   parameter int SCREEN_HEIGHT = gcr_pkg::SCREEN_HEIGHT_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire gcr_pkg::queue_status_type   queue,
   output      logic                        pop,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   output      logic [gcr_pkg::CURSOR_W-1:0] rsp_cursor_row,
   output      logic [gcr_pkg::CURSOR_W-1:0] rsp_cursor_col,
   output      logic [gcr_pkg::COLOR_W-1:0]  rsp_color_out,
   output      logic                        rsp_last
);
   import gcr_pkg::*;

   localparam logic [WIDE_COORD_W-1:0] HeightLimit = WIDE_COORD_W'(SCREEN_HEIGHT);

   logic                     cur_valid_ff, cur_valid_in;
   logic [BITS_PER_BYTE-1:0] cur_mask_ff, cur_mask_in;
   logic [CURSOR_W-1:0]      cur_x_ff;
   logic [COORD_W-1:0]       cur_y_ff;
   logic [COLOR_W-1:0]       cur_color_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CURSOR_W-1:0]      row_ff, col_ff;
   logic [COLOR_W-1:0]       color_ff;
   logic                     last_ff;

   logic                     out_free, advance;
   logic [BITS_PER_BYTE-1:0] one_hot, rest;
   logic [2:0]               bit_index;
   logic [WIDE_COORD_W-1:0]  pixel_y, cursor_row;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = cur_valid_ff && out_free;

   always_comb begin
      one_hot   = cur_mask_ff & (~cur_mask_ff + 1'b1);
      rest      = cur_mask_ff & ~one_hot;
      bit_index = '0;
      for (int i = 0; i < BITS_PER_BYTE; i++) begin
         if (one_hot[i]) begin
            bit_index = bit_index | 3'(i);
         end
      end
      pixel_y    = {1'b0, cur_y_ff} + WIDE_COORD_W'(bit_index);
      cursor_row = HeightLimit - pixel_y;
   end

   // The next byte moves in as soon as the last pixel of this one leaves.
   assign pop = queue.valid && (!cur_valid_ff || (advance && (rest == '0)));

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_mask_in  = cur_mask_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         cur_mask_in  = queue.entry.pixel_mask;
      end else if (advance) begin
         cur_valid_in = (rest != '0);
         cur_mask_in  = rest;
      end
      rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_mask_ff <= cur_mask_in;
      if (pop) begin
         cur_x_ff     <= queue.entry.pixel_x;
         cur_y_ff     <= queue.entry.start_y;
         cur_color_ff <= queue.entry.color;
      end
      if (advance) begin
         row_ff   <= cursor_row[CURSOR_W-1:0];
         col_ff   <= cur_x_ff;
         color_ff <= cur_color_ff;
         last_ff  <= (rest == '0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_row = row_ff;
   assign rsp_cursor_col = col_ff;
   assign rsp_color_out  = color_ff;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire
